[rtl/swm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SCROLL_UP = 2'd1;
  localparam logic [1:0] OP_SCROLL_DOWN = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam int MaxOut = 64;
  localparam logic [6:0] MAX_VISIBLE_RESET = 7'd24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC1,
    ST_EXEC2,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec1;
    logic exec2;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic is_read;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/swm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  output swm_pkg::cmd_t     cmd,
  input  swm_pkg::sts_t     sts
);
  import swm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC1;
        end
      end
      ST_EXEC1: begin
        cmd.exec1 = 1'b1;
        // A read of an empty store gives no items at all.
        if (sts.is_read && sts.empty) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EXEC2;
        end
      end
      ST_EXEC2: begin
        cmd.exec2 = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.out_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/swm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic [6:0]   cfg_data,
  input  wire logic [1:0]   opcode,
  input  wire logic [7:0]   amount,
  input  swm_pkg::cmd_t     cmd,
  output swm_pkg::sts_t     sts,
  output logic [7:0]        slot,
  output logic              last
);
  import swm_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int UW = (PW > 8) ? PW : 8;
  localparam int EW = (PW > 7) ? PW : 7;
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
  localparam logic [PW:0] DEPTH_W = (PW + 1)'(RING_DEPTH);

  logic [1:0]    op;
  logic [7:0]    amt;
  logic [6:0]    max_visible;
  logic [PW-1:0] oldest_slot;
  logic [PW-1:0] newest_slot;
  logic          store_empty;
  logic [PW-1:0] view_first;
  logic [PW-1:0] view_last;
  logic [PW-1:0] used;
  logic [PW-1:0] out_slot;
  logic          out_last;
  logic [6:0]    remaining;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] x);
    ring_inc = (x == LAST_SLOT) ? '0 : PW'(x + 1'b1);
  endfunction

  function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] x,
                                             input logic [PW-1:0] u);
    logic [PW:0] s;
    s = {1'b0, x} + {1'b0, u};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    ring_add = s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] ring_sub(input logic [PW-1:0] x,
                                             input logic [PW-1:0] u);
    logic [PW:0] s;
    if (x >= u) begin
      s = {1'b0, x} - {1'b0, u};
    end else begin
      s = {1'b0, x} + DEPTH_W - {1'b0, u};
    end
    ring_sub = s[PW-1:0];
  endfunction

  // Number of slots from one slot to another going forward, minus one.
  function automatic logic [PW-1:0] gap(input logic [PW-1:0] from,
                                        input logic [PW-1:0] to);
    logic [PW:0] s;
    if (to >= from) begin
      s = {1'b0, to} - {1'b0, from};
    end else begin
      s = {1'b0, to} + DEPTH_W - {1'b0, from};
    end
    gap = s[PW-1:0];
  endfunction

  logic [6:0]    limit;
  logic [PW-1:0] newest_inc;
  logic [PW-1:0] diff;
  logic [UW-1:0] amt_ext;
  logic [EW-1:0] window_gap;
  logic [PW+7:0] slot_ext;

  always_comb begin
    if (max_visible == 7'd0) begin
      limit = 7'd1;
    end else if (max_visible > 7'(MaxOut)) begin
      limit = 7'(MaxOut);
    end else begin
      limit = max_visible;
    end
    newest_inc = ring_inc(newest_slot);
    diff = (op == OP_SCROLL_UP) ? gap(oldest_slot, view_first) : gap(view_last, newest_slot);
    amt_ext = UW'(amt);
    window_gap = EW'(gap(view_first, view_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_visible <= MAX_VISIBLE_RESET;
    end else if (cfg_write) begin
      max_visible <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= opcode;
      amt <= amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
      newest_slot <= '0;
      store_empty <= 1'b1;
      view_first <= '0;
      view_last <= '0;
      used <= '0;
      out_slot <= '0;
      out_last <= 1'b0;
      remaining <= '0;
    end else if (cmd.exec1) begin
      case (op)
        OP_APPEND: begin
          if (store_empty) begin
            store_empty <= 1'b0;
            oldest_slot <= '0;
            newest_slot <= '0;
            view_first <= '0;
            view_last <= '0;
          end else begin
            if (view_last == newest_slot) begin
              view_last <= ring_inc(view_last);
            end
            newest_slot <= newest_inc;
            if (newest_inc == oldest_slot) begin
              oldest_slot <= ring_inc(oldest_slot);
            end
          end
        end
        OP_SCROLL_UP, OP_SCROLL_DOWN: begin
          if (UW'(diff) < amt_ext) begin
            used <= diff;
          end else begin
            used <= amt_ext[PW-1:0];
          end
        end
        default: begin
          if (window_gap >= EW'(MaxOut - 1)) begin
            remaining <= 7'(MaxOut);
          end else begin
            remaining <= 7'(window_gap + 1'b1);
          end
        end
      endcase
    end else if (cmd.exec2) begin
      case (op)
        OP_APPEND: begin
          // Trim the window when it has grown past the visible maximum.
          if (window_gap >= EW'(limit)) begin
            view_first <= ring_inc(view_first);
          end
          out_slot <= newest_slot;
          out_last <= 1'b1;
        end
        OP_SCROLL_UP: begin
          if (!store_empty) begin
            view_first <= ring_sub(view_first, used);
            view_last <= ring_sub(view_last, used);
            out_slot <= ring_sub(view_first, used);
          end else begin
            out_slot <= view_first;
          end
          out_last <= 1'b1;
        end
        OP_SCROLL_DOWN: begin
          if (!store_empty) begin
            view_first <= ring_add(view_first, used);
            view_last <= ring_add(view_last, used);
            out_slot <= ring_add(view_first, used);
          end else begin
            out_slot <= view_first;
          end
          out_last <= 1'b1;
        end
        default: begin
          out_slot <= view_first;
          out_last <= (remaining == 7'd1);
        end
      endcase
    end else if (cmd.step) begin
      out_slot <= ring_inc(out_slot);
      remaining <= remaining - 7'd1;
      out_last <= (remaining == 7'd2);
    end
  end

  assign slot_ext = {8'd0, out_slot};
  assign slot = slot_ext[7:0];
  assign last = out_last;

  assign sts.empty = store_empty;
  assign sts.is_read = (op == OP_READ);
  assign sts.out_last = out_last;

endmodule

`default_nettype wire

[rtl/scrollback_window_manager.sv]
`timescale 1ns / 1ps
`default_nettype none

// Slot-pointer manager for a circular scrollback store whose line text lives
// in an external memory of RING_DEPTH slots. The block tracks the oldest and
// newest stored slots and a visible window that runs forward around the ring.
// An append item returns the slot to write, drops the oldest line when the
// ring is full, and keeps the window at most max_visible lines (clamped to
// 1..64). Scroll items move the window inside the stored range and return
// the new first visible slot. A read item streams the window's slots, up to
// 64, with last set on the final one; a read of an empty store returns
// nothing. Items are handled one at a time: an append or scroll goes through
// acceptance, two update steps through the pointer adder and compare, an output
// step ending in its result handshake; a read goes through acceptance and both
// update steps, then streams its slots. Output stalls hold an item in its
// output step. Slot numbers wider than eight bits are reported in their low
// eight bits. The max_visible register may be written only while idle.

module scrollback_window_manager #(
  parameter int RING_DEPTH = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [6:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] amount,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      slot,
  output logic            last
);
  import swm_pkg::*;

  // Commands and status between the sequencer and the pointer datapath.
  cmd_t cmd;
  sts_t sts;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds all pointers, the configuration register and the
  // output register, so the result stays stable while the output stalls.
  swm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .amount    (amount),
    .cmd       (cmd),
    .sts       (sts),
    .slot      (slot),
    .last      (last)
  );

endmodule

`default_nettype wire
